// ===== sv/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Holds arena sizing, the request and response items and the header format.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int ARENA_GRANULES = 1024;
   localparam int ADDR_W = $clog2(ARENA_GRANULES);
   localparam int END_W = ADDR_W + 1;
   localparam int SIZE_W = 10;
   localparam int HDR_W = SIZE_W + 1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [9:0]  request_size;
      logic [9:0]  release_address;
   } req_type;

   typedef struct packed {
      logic [9:0]  payload_address;
      logic        status;
   } rsp_type;

   // Header word: size in granules above a free mark.
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              free;
   } hdr_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      hdr_type           wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_ctl_type;

endpackage

// ===== sv/ffba_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// ffba_hdr_mem: header store
// One write port and one registered read port over the arena headers.
// ----------------------------------------------------------------------------
module ffba_hdr_mem
   import ffba_pkg::*;
(
   input  logic        clock,
   input  mem_ctl_type ctl,
   output hdr_type     rdata
);

   hdr_type mem_ff [ARENA_GRANULES];
   hdr_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem_ff[ctl.waddr] <= ctl.wdata;
      end
      rdata_ff <= mem_ff[ctl.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top: first-fit allocator over a header-walked arena
// ----------------------------------------------------------------------------
// One item at a time. Allocate and free both walk the block headers from
// granule 0, one header at a time, through the header store's single
// registered read port (issue address, then use data). The walk stops at the
// arena end, at the free target or, for an allocate, at a free block that it
// can split. A free that finds its block also reads the next and previous
// headers, where they exist, for merging. A free of address zero answers
// without a walk. Result items wait in an output register, and a new item is
// taken only after the previous result has left.
// The header store is not cleared: walks never pass end_ff, so unwritten
// headers are never used.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top
   import ffba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_RD     = 10'b0000000010,
      S_WALK   = 10'b0000000100,
      S_SPLIT  = 10'b0000001000,
      S_NXRD   = 10'b0000010000,
      S_NXCHK  = 10'b0000100000,
      S_PVRD   = 10'b0001000000,
      S_PVCHK  = 10'b0010000000,
      S_RESP   = 10'b0100000000,
      S_SELF   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic             op_ff, op_in;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [END_W-1:0] h_ff, h_in;            // free target header (release address minus one)
   logic [END_W-1:0] a_ff, a_in;            // walk pointer
   logic [END_W-1:0] prev_ff, prev_in;
   logic             has_prev_ff, has_prev_in;
   logic [END_W-1:0] end_ff, end_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [END_W:0]   s_ff, s_in;            // merged size
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   mem_ctl_type      ctl;
   hdr_type          rd;

   ffba_hdr_mem u_mem (.clock(clock), .ctl(ctl), .rdata(rd));

   logic [END_W:0] next_a;
   logic [END_W:0] need;
   assign next_a = {1'b0, a_ff} + {{(END_W-SIZE_W+1){1'b0}}, rd.size} + 1'b1;
   assign need = {{(END_W-SIZE_W+1){1'b0}}, n_ff} + 1'b1;

   always_comb begin
      state_in = state_ff; op_in = op_ff; n_in = n_ff; h_in = h_ff; a_in = a_ff;
      prev_in = prev_ff; has_prev_in = has_prev_ff; end_in = end_ff; last_in = last_ff;
      s_in = s_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      ctl = '0;
      ctl.raddr = a_ff[ADDR_W-1:0];
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               op_in = req_data.operation;
               n_in = (req_data.request_size == '0) ? SIZE_W'(1) : req_data.request_size;
               h_in = {1'b0, req_data.release_address} - 1'b1;
               a_in = '0;
               has_prev_in = 1'b0;
               rsp_in = '0;
               if (req_data.operation == OP_FREE && req_data.release_address == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            // Stop at the arena end or the free target; else issue the read.
            if (a_ff >= end_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if ({1'b0, end_ff} + need > (END_W+1)'(ARENA_GRANULES)) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     ctl.we = 1'b1;
                     ctl.waddr = end_ff[ADDR_W-1:0];
                     ctl.wdata = '{size: n_ff, free: 1'b0};
                     last_in = end_ff[ADDR_W-1:0];
                     end_in = END_W'({1'b0, end_ff} + need);
                     rsp_in.payload_address = 10'(end_ff + 1'b1);
                  end
               end
               state_in = S_RESP;
            end else if (op_ff == OP_FREE && a_ff == h_ff) begin
               state_in = S_SELF;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (op_ff == OP_ALLOC && rd.free
                && {1'b0, {(END_W-SIZE_W){1'b0}}, rd.size} > need) begin
               ctl.we = 1'b1;
               ctl.waddr = a_ff[ADDR_W-1:0];
               ctl.wdata = '{size: n_ff, free: 1'b0};
               s_in = {{(END_W-SIZE_W+1){1'b0}}, rd.size} - need;
               state_in = S_SPLIT;
            end else begin
               prev_in = a_ff;
               has_prev_in = 1'b1;
               a_in = END_W'(next_a);
               if (next_a[END_W]) a_in = end_ff;
               state_in = S_RD;
            end
         end
         S_SPLIT: begin
            ctl.we = 1'b1;
            ctl.waddr = ADDR_W'(a_ff + need);
            ctl.wdata = '{size: SIZE_W'(s_ff), free: 1'b1};
            if (last_ff == a_ff[ADDR_W-1:0]) last_in = ADDR_W'(a_ff + need);
            rsp_in.payload_address = 10'(a_ff + 1'b1);
            state_in = S_RESP;
         end
         S_SELF: begin
            // Data of the target header is now in rd; compute next block.
            s_in = {{(END_W-SIZE_W+1){1'b0}}, rd.size};
            a_in = END_W'(next_a);
            if (h_ff[ADDR_W-1:0] != last_ff && !next_a[END_W]
                && next_a[END_W-1:0] < end_ff) begin
               state_in = S_NXRD;
            end else begin
               state_in = S_NXCHK;
            end
            if (!(h_ff[ADDR_W-1:0] != last_ff && !next_a[END_W]
                  && next_a[END_W-1:0] < end_ff)) begin
               ctl.we = 1'b1;
               ctl.waddr = h_ff[ADDR_W-1:0];
               ctl.wdata = '{size: rd.size, free: 1'b1};
               state_in = S_PVRD;
            end
         end
         S_NXRD: begin
            state_in = S_NXCHK;
         end
         S_NXCHK: begin
            if (rd.free) begin
               s_in = s_ff + {{(END_W-SIZE_W+1){1'b0}}, rd.size} + 1'b1;
               if (last_ff == a_ff[ADDR_W-1:0]) last_in = h_ff[ADDR_W-1:0];
            end
            ctl.we = 1'b1;
            ctl.waddr = h_ff[ADDR_W-1:0];
            ctl.wdata = '{size: SIZE_W'(rd.free ? s_ff + rd.size + 1'b1 : s_ff), free: 1'b1};
            state_in = S_PVRD;
         end
         S_PVRD: begin
            ctl.raddr = prev_ff[ADDR_W-1:0];
            state_in = has_prev_ff ? S_PVCHK : S_RESP;
         end
         S_PVCHK: begin
            if (rd.free) begin
               ctl.we = 1'b1;
               ctl.waddr = prev_ff[ADDR_W-1:0];
               ctl.wdata = '{size: SIZE_W'({{(END_W-SIZE_W+1){1'b0}}, rd.size} + s_ff + 1'b1),
                             free: 1'b1};
               if (last_ff == h_ff[ADDR_W-1:0]) last_in = prev_ff[ADDR_W-1:0];
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         end_ff <= '0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff <= end_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in; n_ff <= n_in; h_ff <= h_in; a_ff <= a_in; prev_ff <= prev_in;
      has_prev_ff <= has_prev_in; s_ff <= s_in; rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the first-fit block allocator
// Sends allocate and free items through a queue-fed driver and checks every
// response item against a behavioral copy of the arena's header walk.
// ----------------------------------------------------------------------------
module tb_top;
   import ffba_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   first_fit_block_allocator_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Arena image: header per granule, end of the arena, last block.
   int unsigned hdr_size[ARENA_GRANULES];
   bit          hdr_free[ARENA_GRANULES];
   int unsigned arena_top;
   int unsigned tail_block;

   req_type     pending_items[$];
   rsp_type     awaited_rsps[$];
   int unsigned live_blocks[$];   // payload addresses of allocated blocks
   int          failures = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;

   // Predict one response and advance the arena image.
   function automatic rsp_type arena_apply(req_type it);
      rsp_type     r;
      int unsigned a, n, s, rest, h, prv, nx;
      bit          has_prv;
      r = '0;
      if (it.operation == OP_ALLOC) begin
         n = (it.request_size == 0) ? 1 : it.request_size;
         a = 0;
         while (a < arena_top) begin
            s = hdr_size[a];
            if (hdr_free[a] && s > n + 1) begin
               rest = a + 1 + n;
               hdr_size[a] = n; hdr_free[a] = 1'b0;
               hdr_size[rest] = s - (n + 1); hdr_free[rest] = 1'b1;
               if (tail_block == a) tail_block = rest;
               r.payload_address = 10'(a + 1);
               return r;
            end
            a += 1 + s;
         end
         if (arena_top + 1 + n > ARENA_GRANULES) begin
            r.status = 1'b1;
            return r;
         end
         a = arena_top;
         hdr_size[a] = n; hdr_free[a] = 1'b0;
         tail_block = a;
         arena_top = a + 1 + n;
         r.payload_address = 10'(a + 1);
         return r;
      end
      if (it.release_address == 0) return r;
      h = it.release_address - 1;
      a = 0; prv = 0; has_prv = 1'b0;
      while (a < arena_top && a != h) begin
         prv = a; has_prv = 1'b1;
         a += 1 + hdr_size[a];
      end
      if (a != h || a >= arena_top) return r;
      s = hdr_size[h];
      if (h != tail_block) begin
         nx = h + 1 + s;
         if (nx < arena_top && hdr_free[nx]) begin
            s += hdr_size[nx] + 1;
            if (tail_block == nx) tail_block = h;
         end
      end
      hdr_size[h] = s; hdr_free[h] = 1'b1;
      if (has_prv && hdr_free[prv]) begin
         hdr_size[prv] = hdr_size[prv] + s + 1;
         if (tail_block == h) tail_block = prv;
      end
      return r;
   endfunction

   // Queue an item; track allocations so frees mostly hit real blocks.
   task automatic push_item(bit op, int unsigned sz, int unsigned adr);
      req_type it;
      rsp_type r;
      it.operation = op;
      it.request_size = 10'(sz);
      it.release_address = 10'(adr);
      pending_items.push_back(it);
      r = arena_apply(it);
      awaited_rsps.push_back(r);
      if (op == OP_ALLOC && r.status == 1'b0) live_blocks.push_back(r.payload_address);
   endtask

   task automatic random_item();
      int unsigned k, sz;
      k = $urandom_range(0, 99);
      if (k < 45 || live_blocks.size() == 0) begin
         // mostly small sizes, a few large ones
         sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
         push_item(OP_ALLOC, sz, $urandom_range(0, 1023));
      end else if (k < 90) begin
         sz = $urandom_range(0, live_blocks.size() - 1);
         push_item(OP_FREE, $urandom_range(0, 1023), live_blocks[sz]);
         live_blocks.delete(sz);
      end else begin
         // stray free: random address, mostly invalid
         push_item(OP_FREE, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
   endtask

   // Driver: hold valid and payload until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: drive ready, compare each accepted response with the oldest expected.
   // Hold ready low while the hold count runs down.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("unexpected response item %h", rsp_data);
               failures++;
            end else begin
               e = awaited_rsps.pop_front();
               if (rsp_data.payload_address !== e.payload_address) begin
                  $error("payload_address expected %0d actual %0d",
                         e.payload_address, rsp_data.payload_address);
                  failures++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  failures++;
               end
            end
         end
         rsp_ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
         if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      end
   end

   // Watchdog: count cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[first_fit_block_allocator_top] ERROR");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || awaited_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int i;
      arena_top = 0;
      tail_block = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, zero request, bad frees, merges, out of memory.
      push_item(OP_ALLOC, 0, 1023);      // zero request acts as one, payload 1
      push_item(OP_ALLOC, 1, 0);         // payload 3
      push_item(OP_ALLOC, 5, 0);         // payload 5
      push_item(OP_ALLOC, 3, 0);         // payload 11
      push_item(OP_FREE, 1023, 0);       // address zero is ignored
      push_item(OP_FREE, 0, 7);          // inside a payload, ignored
      push_item(OP_FREE, 0, 1023);       // past the arena, ignored
      push_item(OP_FREE, 0, 5);          // plain free, neighbors in use
      push_item(OP_FREE, 0, 3);          // merge with next
      push_item(OP_FREE, 0, 3);          // free of a free block
      push_item(OP_FREE, 0, 1);          // merge with next again
      push_item(OP_ALLOC, 2, 0);         // split the merged block
      push_item(OP_ALLOC, 1023, 0);      // out of memory
      push_item(OP_ALLOC, 1000, 0);
      push_item(OP_ALLOC, 1023, 0);
      push_item(OP_FREE, 0, 11);         // merge with a free previous block
      push_item(OP_FREE, 0, 14);         // inside a merged block, ignored
      push_item(OP_ALLOC, 682, 341);     // alternating bits
      push_item(OP_FREE, 341, 682);
      live_blocks.delete();
      wait_drained();

      // Receiver holds off for a long stretch while the sender keeps offering.
      hold_cycles = 400;
      for (i = 0; i < 20; i++) random_item();
      wait (hold_cycles == 0);
      wait_drained();

      send_idle_pct = 21; recv_idle_pct = 83;
      for (i = 0; i < 250; i++) random_item();
      wait_drained();   // sender pauses until all responses are in
      send_idle_pct = 83; recv_idle_pct = 21;
      for (i = 0; i < 250; i++) random_item();
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      for (i = 0; i < 230; i++) random_item();
      wait_drained();
      repeat (50) @(posedge clock);

      if (failures == 0 && awaited_rsps.size() == 0) begin
         $display("[first_fit_block_allocator_top] OK");
      end else begin
         $display("[first_fit_block_allocator_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ffba_pkg.sv
sv/ffba_hdr_mem.sv
sv/first_fit_block_allocator_top.sv
dv/tb_top.sv
